### rtl/core/slps_pkg.sv
// Package for the status LED pattern sequencer.
// Holds widths, opcodes, pattern codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package slps_pkg;

  localparam int CODE_W     = 4;
  localparam int TIME_W     = 32;
  localparam int LEN_W      = 24;
  localparam int PERIOD_W   = 16;
  localparam int HALF_W     = PERIOD_W - 1;
  localparam int REM_W      = PERIOD_W;
  localparam int CNT_W      = 5;
  localparam int CHAN_W     = 8;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_BG    = 2'd1;
  localparam logic [OP_W-1:0] OP_SHOW_TEMP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OK_DUR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_PER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_CNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HAZ_DUR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HAZ_PER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NETERR_DUR = 3'd5;

  localparam logic [CODE_W-1:0] PAT_OFF        = 4'd0;
  localparam logic [CODE_W-1:0] PAT_IDLE       = 4'd1;
  localparam logic [CODE_W-1:0] PAT_BOOTING    = 4'd2;
  localparam logic [CODE_W-1:0] PAT_WIFI       = 4'd3;
  localparam logic [CODE_W-1:0] PAT_PROCESSING = 4'd4;
  localparam logic [CODE_W-1:0] PAT_OK         = 4'd5;
  localparam logic [CODE_W-1:0] PAT_WARNING    = 4'd6;
  localparam logic [CODE_W-1:0] PAT_HAZARD     = 4'd7;
  localparam logic [CODE_W-1:0] PAT_NETERR     = 4'd8;
  localparam logic [CODE_W-1:0] PAT_BINFULL    = 4'd9;
  localparam logic [CODE_W-1:0] PAT_NONE       = 4'd15;

  localparam logic [PERIOD_W-1:0] WIFI_PERIOD_MS   = 16'd600;
  localparam logic [LEN_W-1:0]    BOOTING_LEN_MS   = 24'd1000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] r;
  } rgb_t;

endpackage

### rtl/core/status_led_pattern_sequencer.sv
// Status LED pattern sequencer: background and temporary patterns, expiry and
// blink phase via a bit-serial restoring divider shared across ticks.
// Depends on slps_pkg.
`timescale 1ns / 1ps
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser opcode, s_tdata pattern, now_ms
// m_*      out  m_tvalid/m_tready  m_tdata red, green, blue, lit, shown_pattern
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Set and show transactions are taken in the idle state. A tick passes through
// evaluate and emit when the pattern is solid, with the divide state between them
// when it blinks: the one-bit-a-cycle divider of elapsed time by half the period.
// rst is synchronous; config returns to defaults, nothing rendered yet.
// The result sits in an output register; a stalled output only holds the
// block in its final tick cycle until the register frees. cfg_ready is high.

module status_led_pattern_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [3:0] pattern, [35:4] now_ms, [39:36] zero
  input  logic [slps_pkg::IN_DATA_W-1:0]     s_tdata,
  // [1:0] opcode
  input  logic [slps_pkg::OP_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [24] lit, [28:25] shown_pattern,
  // [31:29] zero
  output logic [slps_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [slps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import slps_pkg::*;

  logic [PERIOD_W-1:0] ok_duration_ms;
  logic [PERIOD_W-1:0] warning_period_ms;
  logic [CHAN_W-1:0]   warning_blink_count;
  logic [PERIOD_W-1:0] hazard_duration_ms;
  logic [PERIOD_W-1:0] hazard_period_ms;
  logic [PERIOD_W-1:0] net_error_duration_ms;

  logic [CODE_W-1:0] background_code;
  logic [CODE_W-1:0] temp_code;
  logic              temp_active;
  logic [TIME_W-1:0] temp_start_ms;
  logic [LEN_W-1:0]  temp_length_ms;
  logic [CODE_W-1:0] last_code;
  logic              last_lit;

  seq_state_t state, state_next;

  logic [TIME_W-1:0] now_q;
  logic [CODE_W-1:0] active_code;
  logic [TIME_W-1:0] elapsed;
  logic [HALF_W-1:0] half;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  bit_cnt;
  logic              on_q;

  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_valid;

  function automatic rgb_t colour_of(input logic [CODE_W-1:0] c);
    rgb_t v;
    v = '0;
    unique case (c)
      PAT_IDLE:       v.g = 8'd24;
      PAT_BOOTING:    begin v.r = 8'd40; v.b = 8'd40; end
      PAT_WIFI:       v.b = 8'd255;
      PAT_PROCESSING: v.b = 8'd255;
      PAT_OK:         v.g = 8'd255;
      PAT_WARNING:    v.r = 8'd255;
      PAT_HAZARD:     v.r = 8'd255;
      PAT_NETERR:     begin v.r = 8'd255; v.g = 8'd140; end
      PAT_BINFULL:    v.r = 8'd255;
      default:        v = '0;
    endcase
    return v;
  endfunction

  // Pattern code cleaning and decode of the input transaction
  logic [OP_W-1:0]   in_op;
  logic [CODE_W-1:0] in_raw_code;
  logic [CODE_W-1:0] in_code;
  logic [TIME_W-1:0] in_now;
  logic              in_acc;
  logic [LEN_W-1:0]  in_dur;
  logic [LEN_W-1:0]  warn_dur;

  assign in_op       = s_tuser;
  assign in_raw_code = s_tdata[CODE_W-1:0];
  assign in_code     = (in_raw_code > PAT_BINFULL) ? PAT_OFF : in_raw_code;
  assign in_now      = s_tdata[CODE_W +: TIME_W];
  assign in_acc      = s_tvalid && s_tready;
  assign warn_dur    = LEN_W'(warning_blink_count) * LEN_W'(warning_period_ms);

  always_comb begin
    unique case (in_code)
      PAT_BOOTING: in_dur = BOOTING_LEN_MS;
      PAT_OK:      in_dur = LEN_W'(ok_duration_ms);
      PAT_WARNING: in_dur = warn_dur;
      PAT_HAZARD:  in_dur = LEN_W'(hazard_duration_ms);
      PAT_NETERR:  in_dur = LEN_W'(net_error_duration_ms);
      default:     in_dur = '0;
    endcase
  end

  // Tick evaluation: expiry, active pattern, time base, half period
  logic [TIME_W-1:0]   temp_diff;
  logic                expired;
  logic                keep_temp;
  logic [CODE_W-1:0]   eval_code;
  logic [PERIOD_W-1:0] eval_period;
  logic [HALF_W-1:0]   eval_half;

  assign temp_diff = now_q - temp_start_ms;
  assign expired   = temp_active && (temp_length_ms != '0) &&
                     (temp_diff >= TIME_W'(temp_length_ms));
  assign keep_temp = temp_active && !expired;
  assign eval_code = keep_temp ? temp_code : background_code;

  always_comb begin
    unique case (eval_code)
      PAT_WIFI:    eval_period = WIFI_PERIOD_MS;
      PAT_WARNING: eval_period = warning_period_ms;
      PAT_HAZARD:  eval_period = hazard_period_ms;
      default:     eval_period = '0;
    endcase
  end

  assign eval_half = eval_period[PERIOD_W-1:1];

  // Divider step: one quotient bit a cycle, MSB of elapsed first
  logic [REM_W-1:0] div_shift;
  logic [REM_W:0]   div_trial;
  logic             div_qbit;

  assign div_shift = {rem[REM_W-2:0], elapsed[TIME_W-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, half};
  assign div_qbit  = !div_trial[REM_W];

  logic changed;
  logic out_free;
  rgb_t emit_rgb;

  assign changed  = (active_code != last_code) || (on_q != last_lit);
  assign out_free = !out_valid || m_tready;
  assign emit_rgb = on_q ? colour_of(active_code) : '0;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc && in_op == OP_TICK) state_next = ST_EVAL;
      ST_EVAL: state_next = (eval_half == '0) ? ST_EMIT : ST_DIV;
      ST_DIV:  if (bit_cnt == '0) state_next = ST_EMIT;
      ST_EMIT: if (!changed || out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  logic eval_en;
  logic div_en;
  logic load_out;

  always_comb begin
    s_tready = 1'b0;
    eval_en  = 1'b0;
    div_en   = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_EVAL: eval_en  = 1'b1;
      ST_DIV:  div_en   = 1'b1;
      ST_EMIT: load_out = changed && out_free;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ok_duration_ms        <= 16'd1500;
      warning_period_ms     <= 16'd400;
      warning_blink_count   <= 8'd3;
      hazard_duration_ms    <= 16'd5000;
      hazard_period_ms      <= 16'd200;
      net_error_duration_ms <= 16'd2000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OK_DUR:     ok_duration_ms        <= cfg_data;
        REG_WARN_PER:   warning_period_ms     <= cfg_data;
        REG_WARN_CNT:   warning_blink_count   <= cfg_data[CHAN_W-1:0];
        REG_HAZ_DUR:    hazard_duration_ms    <= cfg_data;
        REG_HAZ_PER:    hazard_period_ms      <= cfg_data;
        REG_NETERR_DUR: net_error_duration_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      background_code <= PAT_OFF;
      temp_code       <= PAT_OFF;
      temp_active     <= 1'b0;
      temp_start_ms   <= '0;
      temp_length_ms  <= '0;
      last_code       <= PAT_NONE;
      last_lit        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (in_op == OP_SET_BG) begin
          background_code <= in_code;
        end else if (in_op == OP_SHOW_TEMP) begin
          // timed pattern already running is left alone
          if (!(in_dur != '0 && temp_active && temp_code == in_code)) begin
            temp_code      <= in_code;
            temp_active    <= 1'b1;
            temp_start_ms  <= in_now;
            temp_length_ms <= in_dur;
          end
        end
      end
      if (eval_en) temp_active <= keep_temp;
      if (load_out) begin
        last_code <= active_code;
        last_lit  <= on_q;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) now_q <= in_now;
    if (eval_en) begin
      active_code <= eval_code;
      elapsed     <= keep_temp ? temp_diff : now_q;
      half        <= eval_half;
      rem         <= '0;
      bit_cnt     <= CNT_W'(TIME_W - 1);
      on_q        <= 1'b1;
    end
    if (div_en) begin
      rem     <= div_qbit ? div_trial[REM_W-1:0] : div_shift;
      elapsed <= {elapsed[TIME_W-2:0], 1'b0};
      bit_cnt <= bit_cnt - 1'b1;
      on_q    <= !div_qbit;
    end
    if (load_out) begin
      out_data <= {3'b000, active_code, on_q, emit_rgb};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_dark_is_black: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[24] |-> m_tdata[23:0] == '0)
    else $error("dark result carries colour");

  a_shown_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[28:25] <= PAT_BINFULL)
    else $error("shown pattern out of range");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_TICK |=> !s_tready)
    else $error("ready during tick evaluation");

  a_last_tracks_out: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid && m_tdata[28:25] == last_code && m_tdata[24] == last_lit)
    else $error("rendered state differs from result");

endmodule

### tb/status_led_pattern_sequencer_tb.sv
// Self-checking testbench for status_led_pattern_sequencer: a directed table, then
// random set/show/tick traffic under several register settings, scored by a predictor.
// Depends on slps_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module status_led_pattern_sequencer_tb;
  import slps_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [CODE_W-1:0] PAT_BOGUS   = 4'd12;
  localparam int                SETTLE_CYC  = 50;
  // slowest tick runs the full divide plus short random stalls; idle pauses are SETTLE_CYC
  localparam int                QUIET_LIMIT = 3000;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic              lit;
    logic [CODE_W-1:0] shown;
  } led_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   r;
    logic [CHAN_W-1:0]   g;
    logic [CHAN_W-1:0]   b;
    logic [TIME_W-1:0]   dur;
    logic [PERIOD_W-1:0] period;
  } look_t;

  typedef enum bit [1:0] {BY_MODEL, NO_LED, LED_IS} row_chk_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] pat;
    logic [TIME_W-1:0] now;
    row_chk_t          chk;
    led_t              led;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  status_led_pattern_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of registers and state
  logic [15:0]       ok_ms, warn_per, haz_ms, haz_per, neterr_ms;
  logic [7:0]        warn_cnt;
  logic [CODE_W-1:0] bg_code, tmp_code, shown_code;
  logic              tmp_on, shown_lit;
  logic [TIME_W-1:0] tmp_start, tmp_len;

  led_t     led_q[$];
  row_t     dir_tab[$];
  row_chk_t cur_chk;
  led_t     cur_led;
  bit       gaps_on;
  int       quiet, n_bad, n_items, n_ticks, n_results, n_settings;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic look_t look_for(input logic [CODE_W-1:0] code);
    look_t lk;
    lk = '0;
    case (code)
      PAT_IDLE: lk.g = 8'd24;
      PAT_BOOTING: begin
        lk.r = 8'd40;
        lk.b = 8'd40;
        lk.dur = 32'd1000;
      end
      PAT_WIFI: begin
        lk.b = 8'd255;
        lk.period = 16'd600;
      end
      PAT_PROCESSING: lk.b = 8'd255;
      PAT_OK: begin
        lk.g = 8'd255;
        lk.dur = {16'd0, ok_ms};
      end
      PAT_WARNING: begin
        lk.r = 8'd255;
        lk.dur = {24'd0, warn_cnt} * {16'd0, warn_per};
        lk.period = warn_per;
      end
      PAT_HAZARD: begin
        lk.r = 8'd255;
        lk.dur = {16'd0, haz_ms};
        lk.period = haz_per;
      end
      PAT_NETERR: begin
        lk.r = 8'd255;
        lk.g = 8'd140;
        lk.dur = {16'd0, neterr_ms};
      end
      PAT_BINFULL: lk.r = 8'd255;
      default: ;
    endcase
    return lk;
  endfunction

  // advances the pattern state by one transaction; has is set when the LED changes
  function automatic void render_led(input logic [OP_W-1:0] op,
                                     input logic [CODE_W-1:0] raw,
                                     input logic [TIME_W-1:0] now,
                                     output bit has, output led_t res);
    logic [CODE_W-1:0] code, act;
    logic [TIME_W-1:0] el;
    logic [15:0]       half;
    look_t             lk;
    bit                on;
    has = 1'b0;
    res = '0;
    code = (raw > PAT_BINFULL) ? PAT_OFF : raw;
    case (op)
      OP_SET_BG: bg_code = code;
      OP_SHOW_TEMP: begin
        lk = look_for(code);
        if (!(lk.dur != 0 && tmp_on && tmp_code == code)) begin
          tmp_code = code;
          tmp_on = 1'b1;
          tmp_start = now;
          tmp_len = lk.dur;
        end
      end
      OP_TICK: begin
        el = now - tmp_start;
        if (tmp_on && tmp_len != 0 && el >= tmp_len) tmp_on = 1'b0;
        act = tmp_on ? tmp_code : bg_code;
        el = tmp_on ? now - tmp_start : now;
        lk = look_for(act);
        half = lk.period >> 1;
        on = 1'b1;
        if (half != 0) on = ((el / {16'd0, half}) % 2) == 0;
        if (act != shown_code || on != shown_lit) begin
          shown_code = act;
          shown_lit = on;
          has = 1'b1;
          res.r = on ? lk.r : 8'd0;
          res.g = on ? lk.g : 8'd0;
          res.b = on ? lk.b : 8'd0;
          res.lit = on;
          res.shown = act;
        end
      end
      default: ;
    endcase
  endfunction

  always @(negedge clk) m_tready <= !(gaps_on && $urandom_range(99) < 6);

  always @(posedge clk) begin : scoreboard_b
    led_t want, got;
    bit   has, moved;
    if (!rst) begin
      moved = 1'b0;
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        n_results++;
        got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[24], m_tdata[28:25]};
        if (led_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: unexpected LED result r%0d g%0d b%0d lit%0d pat%0d", $realtime,
                     got.r, got.g, got.b, got.lit, got.shown);
        end else begin
          want = led_q.pop_front();
          if (want != got) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: LED mismatch, exp r%0d g%0d b%0d lit%0d pat%0d, got r%0d g%0d b%0d lit%0d pat%0d",
                       $realtime, want.r, want.g, want.b, want.lit, want.shown,
                       got.r, got.g, got.b, got.lit, got.shown);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_OK_DUR:     ok_ms = cfg_data;
          REG_WARN_PER:   warn_per = cfg_data;
          REG_WARN_CNT:   warn_cnt = cfg_data[7:0];
          REG_HAZ_DUR:    haz_ms = cfg_data;
          REG_HAZ_PER:    haz_per = cfg_data;
          REG_NETERR_DUR: neterr_ms = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        n_items++;
        if (s_tuser == OP_TICK) n_ticks++;
        render_led(s_tuser, s_tdata[3:0], s_tdata[35:4], has, want);
        if (cur_chk == LED_IS) begin
          has = 1'b1;
          want = cur_led;
        end else if (cur_chk == NO_LED) begin
          has = 1'b0;
        end
        if (has) led_q.push_back(want);
      end
      quiet = moved ? 0 : quiet + 1;
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("Timed out: no transaction for %0d cycles, %0d results pending",
             QUIET_LIMIT, led_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // called and returns at a falling edge; tvalid is left high for the next item
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] pat,
                           input logic [TIME_W-1:0] now, input row_chk_t chk,
                           input led_t led);
    while (gaps_on && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    cur_chk = chk;
    cur_led = led;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'd0, now, pat};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all(input logic [15:0] ok, input logic [15:0] wp, input logic [7:0] wc,
                         input logic [15:0] hd, input logic [15:0] hp, input logic [15:0] nd);
    write_reg(REG_OK_DUR, ok);
    write_reg(REG_WARN_PER, wp);
    write_reg(REG_WARN_CNT, {8'd0, wc});
    write_reg(REG_HAZ_DUR, hd);
    write_reg(REG_HAZ_PER, hp);
    write_reg(REG_NETERR_DUR, nd);
    n_settings++;
  endtask

  // sender holds off until every result is back and the last tick has finished
  task automatic settle();
    while (led_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly a clock moving forward in steps near the blink and expiry scales,
  // with occasional large jumps and random restarts of the time base
  task automatic run_traffic(input int n, input logic [TIME_W-1:0] t0);
    logic [TIME_W-1:0] t;
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] pat;
    int                scale, r, sent, k;
    t = t0;
    sent = 0;
    scale = 100;
    k = 0;
    while (sent < n) begin
      if (k % 32 == 0) begin
        case ($urandom_range(3))
          0: scale = 3;
          1: scale = 120;
          2: scale = 700;
          default: scale = 40000;
        endcase
      end
      k++;
      r = $urandom_range(99);
      if (r < 70) t = t + $urandom_range(scale);
      else if (r < 92) t = t + $urandom_range(scale * 8);
      else if (r < 98) t = t + $urandom;
      else t = $urandom;
      r = $urandom_range(99);
      if (r < 68) op = OP_TICK;
      else if (r < 78) op = OP_SET_BG;
      else if (r < 95) op = OP_SHOW_TEMP;
      else op = OP_UNUSED;
      pat = ($urandom_range(99) < 85) ? CODE_W'($urandom_range(9)) :
                                        CODE_W'($urandom_range(15, 10));
      send_item(op, pat, t, BY_MODEL, '0);
      if (op != OP_UNUSED) sent++;
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_TICK;
    cfg_valid = 1'b0;
    cfg_index = REG_OK_DUR;
    cfg_data = '0;
    gaps_on = 1'b1;
    cur_chk = BY_MODEL;
    cur_led = '0;
    quiet = 0;
    n_bad = 0;
    n_items = 0;
    n_ticks = 0;
    n_results = 0;
    n_settings = 1;
    ok_ms = 16'd1500;
    warn_per = 16'd400;
    warn_cnt = 8'd3;
    haz_ms = 16'd5000;
    haz_per = 16'd200;
    neterr_ms = 16'd2000;
    bg_code = PAT_OFF;
    tmp_code = PAT_OFF;
    tmp_on = 1'b0;
    tmp_start = '0;
    tmp_len = '0;
    shown_code = PAT_NONE;
    shown_lit = 1'b0;

    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'd0, LED_IS, '{8'd0, 8'd0, 8'd0, 1'b1, PAT_OFF}});
    dir_tab.push_back('{OP_UNUSED, PAT_BINFULL, 32'd7, NO_LED, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'd8, NO_LED, '0});
    dir_tab.push_back('{OP_SET_BG, PAT_IDLE, 32'd10, BY_MODEL, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'd20, LED_IS, '{8'd0, 8'd24, 8'd0, 1'b1, PAT_IDLE}});
    dir_tab.push_back('{OP_SET_BG, PAT_BOGUS, 32'd30, BY_MODEL, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'd40, LED_IS, '{8'd0, 8'd0, 8'd0, 1'b1, PAT_OFF}});
    dir_tab.push_back('{OP_SET_BG, PAT_IDLE, 32'd50, BY_MODEL, '0});
    dir_tab.push_back('{OP_SHOW_TEMP, PAT_OK, 32'd1000, BY_MODEL, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'd1000, LED_IS, '{8'd0, 8'd255, 8'd0, 1'b1, PAT_OK}});
    // timed pattern already running: no restart
    dir_tab.push_back('{OP_SHOW_TEMP, PAT_OK, 32'd2000, BY_MODEL, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'd2499, NO_LED, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'd2500, LED_IS, '{8'd0, 8'd24, 8'd0, 1'b1, PAT_IDLE}});
    dir_tab.push_back('{OP_SHOW_TEMP, PAT_HAZARD, 32'd10000, BY_MODEL, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'd10000,
                        LED_IS, '{8'd255, 8'd0, 8'd0, 1'b1, PAT_HAZARD}});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'd10150,
                        LED_IS, '{8'd0, 8'd0, 8'd0, 1'b0, PAT_HAZARD}});
    // expiry across the 32-bit wrap
    dir_tab.push_back('{OP_SHOW_TEMP, PAT_NETERR, 32'hFFFF_FF00, BY_MODEL, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'h0000_0100,
                        LED_IS, '{8'd255, 8'd140, 8'd0, 1'b1, PAT_NETERR}});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'h0000_06D0,
                        LED_IS, '{8'd0, 8'd24, 8'd0, 1'b1, PAT_IDLE}});
    // persistent pattern restarts its blink on every show
    dir_tab.push_back('{OP_SHOW_TEMP, PAT_WIFI, 32'h8000_0000, BY_MODEL, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'h8000_012C,
                        LED_IS, '{8'd0, 8'd0, 8'd0, 1'b0, PAT_WIFI}});
    dir_tab.push_back('{OP_SHOW_TEMP, PAT_WIFI, 32'hFFFF_FFFF, BY_MODEL, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'hFFFF_FFFF,
                        LED_IS, '{8'd0, 8'd0, 8'd255, 1'b1, PAT_WIFI}});
    dir_tab.push_back('{OP_SHOW_TEMP, PAT_NONE, 32'd0, BY_MODEL, '0});
    dir_tab.push_back('{OP_TICK, PAT_OFF, 32'd0, LED_IS, '{8'd0, 8'd0, 8'd0, 1'b1, PAT_OFF}});

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i])
      send_item(dir_tab[i].op, dir_tab[i].pat, dir_tab[i].now, dir_tab[i].chk, dir_tab[i].led);
    s_tvalid <= 1'b0;

    settle();
    set_all(16'd0, 16'd2, 8'd1, 16'd0, 16'd2, 16'd0);
    run_traffic(370, $urandom);

    settle();
    set_all(16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    gaps_on = 1'b0;
    run_traffic(370, 32'hFFFF_0000);
    gaps_on = 1'b1;

    repeat (2) begin
      settle();
      set_all(16'($urandom_range(4000)), 16'($urandom_range(800, 2)),
              8'($urandom_range(8, 1)), 16'($urandom_range(6000)),
              16'($urandom_range(500, 2)), 16'($urandom_range(3000)));
      run_traffic(370, $urandom);
    end

    settle();
    set_all(16'd1500, 16'd400, 8'd3, 16'd5000, 16'd200, 16'd2000);
    run_traffic(370, $urandom);

    while (led_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Ran %0d input transactions (%0d ticks) over %0d register settings,",
             n_items, n_ticks, n_settings);
    $display("compared %0d LED results, %0d mismatches.", n_results, n_bad);
    if (n_bad == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
